@@ hdl/hhdf_pkg.sv @@
// ----------------------------------------------------------------------------
// hhdf_pkg
// Types, constants and helper functions shared by the hex header deframer.
// ----------------------------------------------------------------------------
package hhdf_pkg;

  localparam int unsigned LenW = 24;
  localparam int unsigned CmdW = 8;
  localparam int unsigned PosW = 4;

  // header byte positions
  localparam logic [PosW-1:0] POS_LEN_FIRST = 4'd0;
  localparam logic [PosW-1:0] POS_LEN_LAST  = 4'd5;
  localparam logic [PosW-1:0] POS_CMD_FIRST = 4'd7;
  localparam logic [PosW-1:0] POS_CMD_LAST  = 4'd8;
  localparam logic [PosW-1:0] POS_HDR_LAST  = 4'd9;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // field parse phase
  typedef enum logic [2:0] {
    PH_SKIP  = 3'b001,
    PH_DIGIT = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [CmdW-1:0] command;
    logic            has_data;
    logic            last;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // letters a-f / A-F: low nibble 1..6 maps to 10..15
      h.value = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ hdl/hhdf_core.sv @@
// ----------------------------------------------------------------------------
// hhdf_core
// Header parser and payload counter; turns one byte into at most one result.
// ----------------------------------------------------------------------------
module hhdf_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              rx_byte,
  output logic                    res_valid,
  output hhdf_pkg::result_t       res
);

  logic [hhdf_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [hhdf_pkg::LenW-1:0] len_r, len_nxt;
  logic [hhdf_pkg::CmdW-1:0] cmd_r, cmd_nxt;
  hhdf_pkg::phase_t          phase_r, phase_nxt;
  logic                      payload_r, payload_nxt;
  logic [hhdf_pkg::LenW-1:0] rem_r, rem_nxt;

  hhdf_pkg::hex_digit_t      digit;
  hhdf_pkg::phase_t          phase_base;
  hhdf_pkg::phase_t          phase_fld;
  logic                      shift_in;
  logic [hhdf_pkg::LenW-1:0] len_base;
  logic [hhdf_pkg::CmdW-1:0] cmd_base;
  logic                      in_len_fld;
  logic                      in_cmd_fld;

  assign digit      = hhdf_pkg::hex_decode(rx_byte);
  assign in_len_fld = (pos_r <= hhdf_pkg::POS_LEN_LAST);
  assign in_cmd_fld = (pos_r == hhdf_pkg::POS_CMD_FIRST) ||
                      (pos_r == hhdf_pkg::POS_CMD_LAST);

  // field starts restart accumulator and phase
  always_comb begin
    phase_base = phase_r;
    len_base   = len_r;
    cmd_base   = cmd_r;
    if (pos_r == hhdf_pkg::POS_LEN_FIRST) begin
      phase_base = hhdf_pkg::PH_SKIP;
      len_base   = '0;
    end else if (pos_r == hhdf_pkg::POS_CMD_FIRST) begin
      phase_base = hhdf_pkg::PH_SKIP;
      cmd_base   = '0;
    end
  end

  // per-field scanner: skip leading spaces, gather hex digits, stop on anything else
  always_comb begin
    shift_in  = 1'b0;
    phase_fld = phase_base;
    if (phase_base == hhdf_pkg::PH_SKIP && rx_byte == hhdf_pkg::CHAR_SPACE) begin
      phase_fld = phase_base;
    end else if (phase_base != hhdf_pkg::PH_DONE && digit.valid) begin
      phase_fld = hhdf_pkg::PH_DIGIT;
      shift_in  = 1'b1;
    end else begin
      phase_fld = hhdf_pkg::PH_DONE;
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    cmd_nxt     = cmd_r;
    phase_nxt   = phase_r;
    payload_nxt = payload_r;
    rem_nxt     = rem_r;
    res_valid   = 1'b0;
    res         = '0;
    if (step) begin
      if (payload_r) begin
        res_valid     = 1'b1;
        res.data_byte = rx_byte;
        res.command   = cmd_r;
        res.has_data  = 1'b1;
        res.last      = (rem_r == hhdf_pkg::LenW'(1));
        rem_nxt       = rem_r - hhdf_pkg::LenW'(1);
        if (rem_nxt == '0) begin
          payload_nxt = 1'b0;
        end
      end else begin
        len_nxt   = len_base;
        cmd_nxt   = cmd_base;
        phase_nxt = phase_base;
        if (in_len_fld) begin
          phase_nxt = phase_fld;
          if (shift_in) begin
            len_nxt = {len_base[hhdf_pkg::LenW-5:0], digit.value};
          end
        end else if (in_cmd_fld) begin
          phase_nxt = phase_fld;
          if (shift_in) begin
            cmd_nxt = {cmd_base[hhdf_pkg::CmdW-5:0], digit.value};
          end
        end
        if (pos_r != hhdf_pkg::POS_HDR_LAST) begin
          pos_nxt = pos_r + hhdf_pkg::PosW'(1);
        end else begin
          pos_nxt = '0;
          rem_nxt = len_nxt;
          if (len_nxt != '0) begin
            payload_nxt = 1'b1;
          end else begin
            // empty message marker
            res_valid   = 1'b1;
            res.command = cmd_nxt;
            res.last    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      len_r     <= '0;
      cmd_r     <= '0;
      phase_r   <= hhdf_pkg::PH_SKIP;
      payload_r <= 1'b0;
      rem_r     <= '0;
    end else begin
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      cmd_r     <= cmd_nxt;
      phase_r   <= phase_nxt;
      payload_r <= payload_nxt;
      rem_r     <= rem_nxt;
    end
  end

endmodule

@@ hdl/hex_header_message_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// hex_header_message_deframer_unit
// Splits a byte stream into messages with ten-byte hex ASCII headers.
// ----------------------------------------------------------------------------
// Takes one byte per transfer and accepts a byte every clock cycle while not
// stalled. A byte is held in an input register, parsed by combinational logic
// and its result, if any, lands in an output register. Header bytes give no
// output; each payload byte gives one transfer with tuser high, and a
// zero-length message gives a single transfer with tuser low and data zero.
// tlast marks the final transfer of a message. Backpressure on the output
// stalls the input only while the output register is full and not being
// taken.
module hex_header_message_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [15:8] command
  output logic        out_tuser,  // has_data
  output logic        out_tlast
);

  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic               out_valid_r, out_valid_nxt;
  hhdf_pkg::result_t  out_res_r;
  logic               advance;
  logic               step;
  logic               res_valid;
  hhdf_pkg::result_t  res;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  hhdf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.command, out_res_r.data_byte};
  assign out_tuser  = out_res_r.has_data;
  assign out_tlast  = out_res_r.last;

endmodule
